>>> hw/rtl/cqs_pkg.sv
// Shared types and constants for the circular queue with search.
package cqs_pkg;

   localparam int DATA_W = 32;
   localparam int SLOT_W = 9;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_DELETE  = 2'd1,
      OP_DISPLAY = 2'd2,
      OP_SEARCH  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0]  value;
   } cmd_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_FETCH,
      B_FLUSH
   } bstate_type;

endpackage

>>> hw/rtl/circular_queue_with_search.sv
// Insert and empty-queue requests are answered from idle; delete and display read storage
// first; search scans each held entry, then flushes its result (one match is held back to
// mark the last). The back end starts a request only when the last is done. One storage
// read port sets the scan rate, one entry per cycle while the result register is free.
// Reset: synchronous, active high; queue empties, head and tail return to slot 1, storage kept.
// Top level: circular queue of signed values with display and search.
module circular_queue_with_search
   import cqs_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_kind,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic [SLOT_W-1:0]        rsp_slot,
   output logic                     rsp_last
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   cqs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .req_value (req_value),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   cqs_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_slot   (rsp_slot),
      .rsp_last   (rsp_last)
   );

endmodule

>>> hw/rtl/cqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/cqs_front.sv
// Front end: accept requests, decode the operation and queue them for the back end.
module cqs_front
   import cqs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_kind,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     cmd_valid,
   output cmd_type                  cmd,
   input  logic                     cmd_pop
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       pop;
   cmd_type    dec;

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      dec.op    = op_type'(req_kind);
      dec.value = req_value;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

>>> hw/rtl/cqs_back.sv
// Back end: run queued operations against the storage and drive the result register.
module cqs_back
   import cqs_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  cmd_type                  cmd,
   output logic                     cmd_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic [SLOT_W-1:0]        rsp_slot,
   output logic                     rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   bstate_type                state_ff, state_in;
   op_type                    op_ff, op_in;
   logic signed [DATA_W-1:0]  key_ff, key_in;
   logic [AW-1:0]             head_ff, head_in;
   logic [AW-1:0]             tail_ff, tail_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             rem_ff, rem_in;
   logic                      found_ff, found_in;
   logic [AW-1:0]             pend_ff, pend_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                rsp_status_ff;
   logic signed [DATA_W-1:0]  rsp_data_ff;
   logic [SLOT_W-1:0]         rsp_slot_ff;
   logic                      rsp_last_ff;

   logic                      out_free;
   logic                      out_load;
   status_type                out_status;
   logic signed [DATA_W-1:0]  out_data;
   logic [SLOT_W-1:0]         out_slot;
   logic                      out_last;

   logic                      wr_en;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   logic [DATA_W-1:0]         rd_data;

   function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
      next_idx = (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
   endfunction

   cqs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (cmd.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      rem_in     = rem_ff;
      found_in   = found_ff;
      pend_in    = pend_ff;
      cmd_pop    = 1'b0;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = head_ff;
      out_load   = 1'b0;
      out_status = ST_OK;
      out_data   = '0;
      out_slot   = '0;
      out_last   = 1'b1;

      case (state_ff)
         B_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop  = 1'b1;
               op_in    = cmd.op;
               key_in   = cmd.value;
               idx_in   = head_ff;
               rem_in   = count_ff - CW'(1);
               found_in = 1'b0;
               case (cmd.op)
                  OP_INSERT: begin
                     out_load = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        out_status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        tail_in  = next_idx(tail_ff);
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_DELETE, OP_DISPLAY: begin
                     if (count_ff == '0) begin
                        out_load   = 1'b1;
                        out_status = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = B_FETCH;
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff == '0) begin
                        out_load   = 1'b1;
                        out_status = ST_NOTFOUND;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = B_FETCH;
                     end
                  end
                  default: begin
                     state_in = B_IDLE;
                  end
               endcase
            end
         end

         B_FETCH: begin
            if (out_free) begin
               case (op_ff)
                  OP_DELETE: begin
                     out_load = 1'b1;
                     out_data = rd_data;
                     count_in = count_ff - CW'(1);
                     // Removing the only entry rewinds both pointers
                     if (count_ff == CW'(1)) begin
                        head_in = '0;
                        tail_in = '0;
                     end else begin
                        head_in = next_idx(head_ff);
                     end
                     state_in = B_IDLE;
                  end
                  OP_DISPLAY: begin
                     out_load = 1'b1;
                     out_data = rd_data;
                     out_slot = SLOT_W'(idx_ff) + SLOT_W'(1);
                     out_last = (rem_ff == '0);
                     if (rem_ff == '0) begin
                        state_in = B_IDLE;
                     end else begin
                        idx_in  = next_idx(idx_ff);
                        rem_in  = rem_ff - CW'(1);
                        rd_en   = 1'b1;
                        rd_addr = next_idx(idx_ff);
                     end
                  end
                  OP_SEARCH: begin
                     // Hold one match back until the next one shows it is not the final one
                     if (rd_data == key_ff) begin
                        if (found_ff) begin
                           out_load = 1'b1;
                           out_slot = SLOT_W'(pend_ff) + SLOT_W'(1);
                           out_last = 1'b0;
                        end
                        found_in = 1'b1;
                        pend_in  = idx_ff;
                     end
                     if (rem_ff == '0) begin
                        state_in = B_FLUSH;
                     end else begin
                        idx_in  = next_idx(idx_ff);
                        rem_in  = rem_ff - CW'(1);
                        rd_en   = 1'b1;
                        rd_addr = next_idx(idx_ff);
                     end
                  end
                  default: begin
                     state_in = B_IDLE;
                  end
               endcase
            end
         end

         B_FLUSH: begin
            if (out_free) begin
               out_load = 1'b1;
               if (found_ff) begin
                  out_slot = SLOT_W'(pend_ff) + SLOT_W'(1);
               end else begin
                  out_status = ST_NOTFOUND;
               end
               state_in = B_IDLE;
            end
         end

         default: begin
            state_in = B_IDLE;
         end
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff   <= op_in;
      key_ff  <= key_in;
      idx_ff  <= idx_in;
      rem_ff  <= rem_in;
      pend_ff <= pend_in;
      if (out_load) begin
         rsp_status_ff <= out_status;
         rsp_data_ff   <= out_data;
         rsp_slot_ff   <= out_slot;
         rsp_last_ff   <= out_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
